[hw/rtl/stp_pkg.sv]
`timescale 1ns / 1ps

package stp_pkg;

    // Audio rate; a whole multiple of 1000 so one millisecond is a whole number of samples
    localparam int SAMPLE_RATE    = 16000;
    localparam int SAMPLES_PER_MS = SAMPLE_RATE / 1000;

    localparam int ACTION_W = 2;
    localparam int FREQ_W   = 13;
    localparam int MS_W     = 16;
    localparam int AMP_W    = 15;
    localparam int GAPMS_W  = 8;
    localparam int SAMPLE_W = 16;
    localparam int PHASE_W  = 14;
    localparam int TONE_W   = 20;
    localparam int GAP_W    = 13;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TONE_AMPLITUDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEGATO_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN_MS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_MAX_MS     = 2'd3;

    localparam logic [AMP_W-1:0]   AMP_RESET     = 15'd32767;
    localparam logic [GAPMS_W-1:0] GAP_MIN_RESET = 8'd12;
    localparam logic [GAPMS_W-1:0] GAP_MAX_RESET = 8'd30;

    localparam logic [TONE_W-1:0] TONE_MAX = {TONE_W{1'b1}};
    localparam logic [GAP_W-1:0]  GAP_MAX  = {GAP_W{1'b1}};

    // ms / 6 as (ms * 43691) >> 18, exact for every 16-bit ms
    localparam logic [MS_W-1:0] DIV6_RECIP = 16'd43691;
    localparam int              DIV6_SHIFT = 18;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [FREQ_W-1:0]   freq_hz;
        logic [MS_W-1:0]     duration_ms;
        logic                restart_phase;
    } note_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       playing;
        logic                       note_end;
    } sample_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_item_t;

    typedef struct packed {
        logic [AMP_W-1:0]   tone_amplitude;
        logic               legato_mode;
        logic [GAPMS_W-1:0] gap_min_ms;
        logic [GAPMS_W-1:0] gap_max_ms;
    } cfg_t;

    typedef struct packed {
        logic [TONE_W-1:0] tone_samples;
        logic [GAP_W-1:0]  gap_samples;
    } note_len_t;

endpackage

[hw/rtl/stp_if.sv]
`timescale 1ns / 1ps

interface stp_note_if;
    logic                valid;
    logic                ready;
    stp_pkg::note_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface stp_sample_if;
    logic                  valid;
    logic                  ready;
    stp_pkg::sample_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface stp_cfg_if;
    logic               valid;
    logic               ready;
    stp_pkg::cfg_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/stp_cfg_regs.sv]
`timescale 1ns / 1ps

module stp_cfg_regs
(
    input  logic          clk,
    input  logic          rst_n,
    stp_cfg_if.sink       cfg,
    output stp_pkg::cfg_t cfg_state
);

    stp_pkg::cfg_t cfg_reg;
    stp_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_state = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.data.index)
                stp_pkg::REG_TONE_AMPLITUDE:
                    cfg_next.tone_amplitude = cfg.data.value[stp_pkg::AMP_W-1:0];
                stp_pkg::REG_LEGATO_MODE:
                    cfg_next.legato_mode = cfg.data.value[0];
                stp_pkg::REG_GAP_MIN_MS:
                    cfg_next.gap_min_ms = cfg.data.value[stp_pkg::GAPMS_W-1:0];
                stp_pkg::REG_GAP_MAX_MS:
                    cfg_next.gap_max_ms = cfg.data.value[stp_pkg::GAPMS_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tone_amplitude <= stp_pkg::AMP_RESET;
            cfg_reg.legato_mode    <= 1'b0;
            cfg_reg.gap_min_ms     <= stp_pkg::GAP_MIN_RESET;
            cfg_reg.gap_max_ms     <= stp_pkg::GAP_MAX_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hw/rtl/stp_note_calc.sv]
`timescale 1ns / 1ps

module stp_note_calc
(
    input  logic [stp_pkg::FREQ_W-1:0] freq_hz,
    input  logic [stp_pkg::MS_W-1:0]   duration_ms,
    input  stp_pkg::cfg_t              cfg_state,
    output stp_pkg::note_len_t         note_len
);

    localparam int QUOT_W  = 2 * stp_pkg::MS_W - stp_pkg::DIV6_SHIFT;
    localparam int MULT_W  = $clog2(stp_pkg::SAMPLES_PER_MS + 1);
    localparam int TPROD_W = stp_pkg::MS_W + MULT_W;
    localparam int GPROD_W = stp_pkg::GAPMS_W + MULT_W;

    logic [2*stp_pkg::MS_W-1:0]  recip_prod;
    logic [QUOT_W-1:0]           gap_quot;
    logic [QUOT_W-1:0]           gap_lo;
    logic [stp_pkg::GAPMS_W-1:0] gap_ms;
    logic [stp_pkg::MS_W-1:0]    on_ms;
    logic                        staccato;
    logic [TPROD_W-1:0]          tone_prod;
    logic [GPROD_W-1:0]          gap_prod;

    always_comb
    begin
        recip_prod = (2*stp_pkg::MS_W)'(duration_ms)
                     * (2*stp_pkg::MS_W)'(stp_pkg::DIV6_RECIP);
        gap_quot   = recip_prod[2*stp_pkg::MS_W-1:stp_pkg::DIV6_SHIFT];

        // raise to the minimum first, then the maximum wins
        gap_lo = (gap_quot < QUOT_W'(cfg_state.gap_min_ms))
                 ? QUOT_W'(cfg_state.gap_min_ms) : gap_quot;
        gap_ms = (gap_lo > QUOT_W'(cfg_state.gap_max_ms))
                 ? cfg_state.gap_max_ms : gap_lo[stp_pkg::GAPMS_W-1:0];

        staccato = (freq_hz != '0) && !cfg_state.legato_mode;
        if (!staccato)
        begin
            gap_ms = '0;
            on_ms  = duration_ms;
        end
        else if (duration_ms > stp_pkg::MS_W'(gap_ms))
        begin
            on_ms = duration_ms - stp_pkg::MS_W'(gap_ms);
        end
        else
        begin
            on_ms = duration_ms;
        end

        tone_prod = TPROD_W'(on_ms) * TPROD_W'(stp_pkg::SAMPLES_PER_MS);
        gap_prod  = GPROD_W'(gap_ms) * GPROD_W'(stp_pkg::SAMPLES_PER_MS);

        note_len.tone_samples = (tone_prod > TPROD_W'(stp_pkg::TONE_MAX))
                                ? stp_pkg::TONE_MAX : stp_pkg::TONE_W'(tone_prod);
        note_len.gap_samples  = (gap_prod > GPROD_W'(stp_pkg::GAP_MAX))
                                ? stp_pkg::GAP_MAX : stp_pkg::GAP_W'(gap_prod);
    end

endmodule

[hw/rtl/square_tone_note_player_unit.sv]
`timescale 1ns / 1ps

// Path: a tick beat is taken on note_in into the input register, then one state update
//   writes its result into the output register.
// Throughput: one beat per cycle while the output register has room; a tick stalls under back-pressure.
// Start and stop beats give no result and pass while a result waits; a tick waits for room.
// Reset: counters, frequency and phase cleared, registers back to their defaults at once.
module square_tone_note_player_unit
(
    input  logic      clk,
    input  logic      rst_n,
    stp_note_if.sink  note_in,
    stp_sample_if.source sample_out,
    stp_cfg_if.sink   cfg
);

    stp_pkg::cfg_t      cfg_state;
    stp_pkg::note_len_t note_len;

    logic                         in_valid_reg;
    stp_pkg::note_item_t          in_item_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    stp_pkg::sample_item_t        out_item_reg;
    stp_pkg::sample_item_t        out_item_next;

    logic [stp_pkg::PHASE_W-1:0]  phase_reg;
    logic [stp_pkg::PHASE_W-1:0]  phase_next;
    logic [stp_pkg::TONE_W-1:0]   tone_left_reg;
    logic [stp_pkg::TONE_W-1:0]   tone_left_next;
    logic [stp_pkg::GAP_W-1:0]    gap_left_reg;
    logic [stp_pkg::GAP_W-1:0]    gap_left_next;
    logic [stp_pkg::FREQ_W-1:0]   freq_reg;
    logic [stp_pkg::FREQ_W-1:0]   freq_next;

    logic                         out_free;
    logic                         is_tick;
    logic                         fire;
    logic [stp_pkg::PHASE_W:0]    phase_sum;

    stp_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_state (cfg_state)
    );

    stp_note_calc u_note_calc
    (
        .freq_hz     (in_item_reg.freq_hz),
        .duration_ms (in_item_reg.duration_ms),
        .cfg_state   (cfg_state),
        .note_len    (note_len)
    );

    assign out_free = !out_valid_reg || sample_out.ready;
    assign is_tick  = (in_item_reg.action == stp_pkg::ACT_TICK);
    // only a tick needs room in the output register
    assign fire     = in_valid_reg && (!is_tick || out_free);

    assign note_in.ready    = !in_valid_reg || fire;
    assign sample_out.valid = out_valid_reg;
    assign sample_out.data  = out_item_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        tone_left_next = tone_left_reg;
        gap_left_next  = gap_left_reg;
        freq_next      = freq_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !sample_out.ready;

        phase_sum = {1'b0, phase_reg} + (stp_pkg::PHASE_W + 1)'(freq_reg);
        if (phase_sum >= (stp_pkg::PHASE_W + 1)'(stp_pkg::SAMPLE_RATE))
        begin
            phase_sum = phase_sum - (stp_pkg::PHASE_W + 1)'(stp_pkg::SAMPLE_RATE);
        end

        if (fire)
        begin
            unique case (in_item_reg.action)
                stp_pkg::ACT_START:
                begin
                    freq_next      = in_item_reg.freq_hz;
                    tone_left_next = note_len.tone_samples;
                    gap_left_next  = note_len.gap_samples;
                    if (in_item_reg.restart_phase)
                    begin
                        phase_next = '0;
                    end
                end
                stp_pkg::ACT_STOP:
                begin
                    freq_next      = '0;
                    tone_left_next = '0;
                    gap_left_next  = '0;
                end
                stp_pkg::ACT_TICK:
                begin
                    out_valid_next         = 1'b1;
                    out_item_next.sample   = '0;
                    out_item_next.playing  = 1'b0;
                    if (tone_left_reg != '0)
                    begin
                        out_item_next.playing = 1'b1;
                        if (freq_reg != '0)
                        begin
                            // high level in the first half of the period
                            if ({1'b0, phase_reg, 1'b0} <
                                (stp_pkg::PHASE_W + 2)'(stp_pkg::SAMPLE_RATE))
                            begin
                                out_item_next.sample =
                                    $signed({1'b0, cfg_state.tone_amplitude});
                            end
                            else
                            begin
                                out_item_next.sample =
                                    -$signed({1'b0, cfg_state.tone_amplitude});
                            end
                            phase_next = phase_sum[stp_pkg::PHASE_W-1:0];
                        end
                        tone_left_next = tone_left_reg - stp_pkg::TONE_W'(1);
                    end
                    else if (gap_left_reg != '0)
                    begin
                        out_item_next.playing = 1'b1;
                        gap_left_next         = gap_left_reg - stp_pkg::GAP_W'(1);
                    end
                    out_item_next.note_end = out_item_next.playing &&
                                             (tone_left_next == '0) &&
                                             (gap_left_next == '0);
                end
                default:
                begin
                    // unused action code: dropped
                    out_valid_next = out_valid_reg && !sample_out.ready;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            tone_left_reg <= '0;
            gap_left_reg  <= '0;
            freq_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= note_in.valid || (in_valid_reg && !fire);
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            tone_left_reg <= tone_left_next;
            gap_left_reg  <= gap_left_next;
            freq_reg      <= freq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (note_in.ready && note_in.valid)
        begin
            in_item_reg <= note_in.data;
        end
        out_item_reg <= out_item_next;
    end

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg < stp_pkg::PHASE_W'(stp_pkg::SAMPLE_RATE))
        else $error("phase out of range");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_item_reg.action == stp_pkg::ACT_STOP
        |=> tone_left_reg == '0 && gap_left_reg == '0 && freq_reg == '0)
        else $error("stop did not clear playback");

    a_tone_plays: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_tick && tone_left_reg != '0
        |=> out_valid_reg && out_item_reg.playing)
        else $error("tone tick not marked playing");

    a_end_implies_playing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.note_end |-> out_item_reg.playing)
        else $error("note end outside a note");

    a_silent_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.playing |-> out_item_reg.sample == '0)
        else $error("sample while idle");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import stp_pkg::*;

    // action code the block must ignore
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int unsigned RUN_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYC  = 6;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned TICK_CAP    = 400;

    typedef struct {
        note_item_t   item;
        bit           typed;
        sample_item_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    stp_note_if   note_ch();
    stp_sample_if sample_ch();
    stp_cfg_if    cfg_ch();

    square_tone_note_player_unit DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .note_in    (note_ch),
        .sample_out (sample_ch),
        .cfg        (cfg_ch)
    );

    // player model state
    cfg_t              regs_now;
    logic [PHASE_W-1:0] phase_acc;
    logic [TONE_W-1:0]  tone_left;
    logic [GAP_W-1:0]   gap_left;
    logic [FREQ_W-1:0]  note_freq;

    sample_item_t expected_samples[$];
    int           errors = 0;
    int unsigned  beats_sent = 0;
    int unsigned  idle_pct = 0;
    int unsigned  stall_pct = 0;
    int unsigned  hold_req = 0;
    int unsigned  hold_seen = 0;
    int unsigned  hold_left = 0;

    always #4 clk = ~clk;

    function automatic note_len_t note_span(input logic [FREQ_W-1:0] freq,
                                            input logic [MS_W-1:0] ms);
        int unsigned     on_ms;
        int unsigned     gap_ms;
        longint unsigned tone_n;
        longint unsigned gap_n;
        note_len_t       span;
        on_ms  = ms;
        gap_ms = 0;
        // staccato: ms/6, raised to the minimum, then capped at the maximum
        if (freq != 0 && !regs_now.legato_mode)
        begin
            gap_ms = ms / 6;
            if (gap_ms < regs_now.gap_min_ms) gap_ms = regs_now.gap_min_ms;
            if (gap_ms > regs_now.gap_max_ms) gap_ms = regs_now.gap_max_ms;
            if (ms > gap_ms) on_ms = ms - gap_ms;
        end
        tone_n = longint'(on_ms) * SAMPLE_RATE / 1000;
        gap_n  = longint'(gap_ms) * SAMPLE_RATE / 1000;
        span.tone_samples = (tone_n > TONE_MAX) ? TONE_MAX : TONE_W'(tone_n);
        span.gap_samples  = (gap_n > GAP_MAX) ? GAP_MAX : GAP_W'(gap_n);
        return span;
    endfunction

    // Advances the player by one beat; returns 1 when the beat yields a sample
    function automatic bit advance_player(input note_item_t it, output sample_item_t res);
        note_len_t                  span;
        logic signed [SAMPLE_W-1:0] level;
        int unsigned                next_phase;
        res = '0;
        case (it.action)
            ACT_START:
            begin
                span      = note_span(it.freq_hz, it.duration_ms);
                note_freq = it.freq_hz;
                tone_left = span.tone_samples;
                gap_left  = span.gap_samples;
                if (it.restart_phase) phase_acc = '0;
                return 1'b0;
            end
            ACT_STOP:
            begin
                tone_left = '0;
                gap_left  = '0;
                note_freq = '0;
                return 1'b0;
            end
            ACT_TICK:
            begin
                if (tone_left != 0)
                begin
                    res.playing = 1'b1;
                    if (note_freq != 0)
                    begin
                        level = {1'b0, regs_now.tone_amplitude};
                        res.sample = (int'(phase_acc) * 2 < SAMPLE_RATE) ? level : -level;
                        next_phase = int'(phase_acc) + int'(note_freq);
                        if (next_phase >= SAMPLE_RATE) next_phase -= SAMPLE_RATE;
                        phase_acc = PHASE_W'(next_phase);
                    end
                    tone_left--;
                end
                else if (gap_left != 0)
                begin
                    res.playing = 1'b1;
                    gap_left--;
                end
                res.note_end = res.playing && tone_left == 0 && gap_left == 0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic dir_row_t dir_entry(input logic [ACTION_W-1:0] action,
                                           input logic [FREQ_W-1:0] freq,
                                           input logic [MS_W-1:0] ms, input logic restart,
                                           input bit typed,
                                           input logic signed [SAMPLE_W-1:0] sample,
                                           input logic playing, input logic note_end);
        dir_row_t r;
        r.item.action        = action;
        r.item.freq_hz       = freq;
        r.item.duration_ms   = ms;
        r.item.restart_phase = restart;
        r.typed              = typed;
        r.want.sample        = sample;
        r.want.playing       = playing;
        r.want.note_end      = note_end;
        return r;
    endfunction

    function automatic note_item_t random_tick();
        note_item_t it;
        it = note_item_t'($urandom);
        it.action = ACT_TICK;
        return it;
    endfunction

    function automatic note_item_t random_start();
        note_item_t it;
        it = note_item_t'($urandom);
        it.action = ACT_START;
        if ($urandom_range(6) == 0) it.freq_hz = '0;
        // mostly short notes so that endings are reached; now and then any length
        case ($urandom_range(9))
            0: ;
            1, 2, 3: it.duration_ms = MS_W'($urandom_range(20, 4));
            default: it.duration_ms = MS_W'($urandom_range(3));
        endcase
        return it;
    endfunction

    task automatic offer_note(input note_item_t it, input bit typed, input sample_item_t want);
        sample_item_t res;
        while ($urandom_range(99) < idle_pct)
        begin
            note_ch.valid <= 1'b0;
            note_ch.data  <= note_item_t'($urandom);
            @(posedge clk);
        end
        note_ch.valid <= 1'b1;
        note_ch.data  <= it;
        @(posedge clk);
        while (!note_ch.ready) @(posedge clk);
        if (advance_player(it, res)) expected_samples.push_back(typed ? want : res);
        if (it.action != ACT_UNUSED) beats_sent++;
    endtask

    task automatic drain_results();
        note_ch.valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // leaves valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.value <= val;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        case (idx)
            REG_TONE_AMPLITUDE: regs_now.tone_amplitude = val[AMP_W-1:0];
            REG_LEGATO_MODE:    regs_now.legato_mode    = val[0];
            REG_GAP_MIN_MS:     regs_now.gap_min_ms     = val[GAPMS_W-1:0];
            REG_GAP_MAX_MS:     regs_now.gap_max_ms     = val[GAPMS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [AMP_W-1:0] amp, input logic legato,
                             input logic [GAPMS_W-1:0] gmin, input logic [GAPMS_W-1:0] gmax,
                             input int unsigned idle, input int unsigned stall,
                             input int unsigned items, input bit with_hold);
        int unsigned  base;
        int unsigned  n;
        int unsigned  k;
        int unsigned  r;
        bit           held;
        bit           paused;
        note_item_t   it;
        note_len_t    span;
        sample_item_t none;
        none   = '0;
        held   = 1'b0;
        paused = 1'b0;
        drain_results();
        // upper data bits carry junk; the block keeps only the field width
        write_reg(REG_TONE_AMPLITUDE, {1'($urandom), amp});
        write_reg(REG_LEGATO_MODE, {15'($urandom), legato});
        write_reg(REG_GAP_MIN_MS, {8'($urandom), gmin});
        write_reg(REG_GAP_MAX_MS, {8'($urandom), gmax});
        cfg_ch.valid <= 1'b0;
        idle_pct  = idle;
        stall_pct = stall;
        base      = beats_sent;
        while (beats_sent - base < items)
        begin
            if (!paused && beats_sent - base >= items / 4)
            begin
                drain_results();
                paused = 1'b1;
            end
            if (with_hold && !held && beats_sent - base >= items / 2)
            begin
                hold_req <= hold_req + 1;
                held = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 70)
            begin
                // a note followed by roughly enough ticks to play it out
                it   = random_start();
                span = note_span(it.freq_hz, it.duration_ms);
                n    = span.tone_samples + span.gap_samples;
                if (n > TICK_CAP) k = $urandom_range(60, 1);
                else if ($urandom_range(4) == 0) k = $urandom_range(n);
                else k = n + $urandom_range(3);
                // keep the phase close to its beat budget
                if (k > items - (beats_sent - base) - 1) k = items - (beats_sent - base) - 1;
                offer_note(it, 1'b0, none);
                repeat (k) offer_note(random_tick(), 1'b0, none);
                if ($urandom_range(9) == 0)
                begin
                    it = note_item_t'($urandom);
                    it.action = ACT_STOP;
                    offer_note(it, 1'b0, none);
                    offer_note(random_tick(), 1'b0, none);
                end
            end
            else if (r < 85)
                offer_note(note_item_t'($urandom), 1'b0, none);
            else
                repeat ($urandom_range(5, 1)) offer_note(random_tick(), 1'b0, none);
        end
    endtask

    // sample receiver: random back-pressure plus the occasional long hold
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen       <= hold_req;
            hold_left       <= HOLD_CYCLES;
            sample_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left       <= hold_left - 1;
            sample_ch.ready <= 1'b0;
        end
        else
            sample_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin : sample_check
        sample_item_t want;
        if (rst_n && sample_ch.valid && sample_ch.ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: sample beat with none expected: sample %0d playing %0b end %0b",
                         $time, $signed(sample_ch.data.sample), sample_ch.data.playing,
                         sample_ch.data.note_end);
                errors++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (sample_ch.data.sample !== want.sample)
                begin
                    $display("%0t: sample: expected %0d, got %0d", $time,
                             $signed(want.sample), $signed(sample_ch.data.sample));
                    errors++;
                end
                if (sample_ch.data.playing !== want.playing)
                begin
                    $display("%0t: playing: expected %0b, got %0b", $time,
                             want.playing, sample_ch.data.playing);
                    errors++;
                end
                if (sample_ch.data.note_end !== want.note_end)
                begin
                    $display("%0t: note_end: expected %0b, got %0b", $time,
                             want.note_end, sample_ch.data.note_end);
                    errors++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: run limit reached, %0d samples outstanding", $time,
                 expected_samples.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        dir_row_t dir_rows [22];
        rst_n           = 1'b0;
        note_ch.valid   = 1'b0;
        note_ch.data    = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        regs_now.tone_amplitude = AMP_RESET;
        regs_now.legato_mode    = 1'b0;
        regs_now.gap_min_ms     = GAP_MIN_RESET;
        regs_now.gap_max_ms     = GAP_MAX_RESET;
        phase_acc = '0;
        tone_left = '0;
        gap_left  = '0;
        note_freq = '0;

        // reset register values throughout
        dir_rows = '{
            dir_entry(ACT_TICK,   13'd0,    16'd0,     1'b0, 1'b1, 16'sd0,      1'b0, 1'b0),
            dir_entry(ACT_UNUSED, 13'h1FFF, 16'hFFFF,  1'b1, 1'b0, 16'sd0,      1'b0, 1'b0),
            dir_entry(ACT_TICK,   13'h1FFF, 16'hFFFF,  1'b1, 1'b1, 16'sd0,      1'b0, 1'b0),
            // half-rate tone: the square flips on every sample
            dir_entry(ACT_START,  13'd8000, 16'hFFFF,  1'b1, 1'b0, 16'sd0,      1'b0, 1'b0),
            dir_entry(ACT_TICK,   13'd0,    16'd0,     1'b0, 1'b1, 16'sd32767,  1'b1, 1'b0),
            dir_entry(ACT_TICK,   13'd0,    16'd0,     1'b0, 1'b1, -16'sd32767, 1'b1, 1'b0),
            dir_entry(ACT_TICK,   13'd0,    16'd0,     1'b0, 1'b1, 16'sd32767,  1'b1, 1'b0),
            // new note over a playing one, step above half rate, phase kept
            dir_entry(ACT_START,  13'h1FFF, 16'd1,     1'b0, 1'b0, 16'sd0,      1'b0, 1'b0),
            dir_entry(ACT_TICK,   13'd0,    16'd0,     1'b0, 1'b0, 16'sd0,      1'b0, 1'b0),
            dir_entry(ACT_TICK,   13'd0,    16'd0,     1'b0, 1'b0, 16'sd0,      1'b0, 1'b0),
            dir_entry(ACT_STOP,   13'h1FFF, 16'hFFFF,  1'b1, 1'b0, 16'sd0,      1'b0, 1'b0),
            dir_entry(ACT_TICK,   13'd0,    16'd0,     1'b0, 1'b1, 16'sd0,      1'b0, 1'b0),
            // rest: silent but playing
            dir_entry(ACT_START,  13'd0,    16'd1,     1'b1, 1'b0, 16'sd0,      1'b0, 1'b0),
            dir_entry(ACT_TICK,   13'd0,    16'd0,     1'b0, 1'b1, 16'sd0,      1'b1, 1'b0),
            // zero-length rest plays nothing
            dir_entry(ACT_START,  13'd0,    16'd0,     1'b0, 1'b0, 16'sd0,      1'b0, 1'b0),
            dir_entry(ACT_TICK,   13'd0,    16'd0,     1'b0, 1'b1, 16'sd0,      1'b0, 1'b0),
            // zero-length tone still gets the minimum gap
            dir_entry(ACT_START,  13'd1,    16'd0,     1'b0, 1'b0, 16'sd0,      1'b0, 1'b0),
            dir_entry(ACT_TICK,   13'd0,    16'd0,     1'b0, 1'b1, 16'sd0,      1'b1, 1'b0),
            dir_entry(ACT_START,  13'd4000, 16'd12,    1'b1, 1'b0, 16'sd0,      1'b0, 1'b0),
            dir_entry(ACT_TICK,   13'd0,    16'd0,     1'b0, 1'b1, 16'sd32767,  1'b1, 1'b0),
            dir_entry(ACT_TICK,   13'd0,    16'd0,     1'b0, 1'b0, 16'sd0,      1'b0, 1'b0),
            dir_entry(ACT_TICK,   13'd0,    16'd0,     1'b0, 1'b0, 16'sd0,      1'b0, 1'b0)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) offer_note(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        run_phase(15'h7FFF, 1'b0, 8'd0,   8'd1,   0,  0,  240, 1'b0);
        run_phase(15'h0000, 1'b1, 8'd255, 8'd255, 77, 0,  240, 1'b0);
        // minimum above maximum: the maximum wins
        run_phase(15'($urandom), 1'b0, 8'd255, 8'd2, 0, 77, 240, 1'b0);
        run_phase(15'h0001, 1'b0, 8'd0,   8'd0,   13, 13, 240, 1'b1);
        run_phase(15'h4000, 1'b0, GAP_MIN_RESET, GAP_MAX_RESET, 0, 0, 240, 1'b0);
        run_phase(15'h2AAA, 1'b0, 8'd0,   8'd255, 13, 13, 250, 1'b0);

        drain_results();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
